[rtl/nps_pkg.sv]
// Shared types and constants for the nearest point on segment set block.
// No dependencies; imported by every module of the block.
`default_nettype none

package nps_pkg;

  localparam int COORD_BITS_DEF  = 20;
  localparam int NODE_BITS_DEF   = 16;
  localparam int T_FRAC_BITS_DEF = 16;

  // |ab|^2 at or below this (0.01 in 8 fraction bits) counts as a point
  localparam int DEGEN_LIMIT = 2;

  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_QUERY_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_QUERY_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_QUERY_Z = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [2:0] {
    MK_NONE,
    MK_LEN,
    MK_DOT,
    MK_PT,
    MK_DST
  } mul_kind_t;

  typedef struct packed {
    mul_kind_t  mul;
    logic [1:0] axis;
    logic       pick_start;
    logic       pick_end;
    logic       div_init;
    logic       div_step;
    logic       commit;
    logic       emit;
  } nps_cmd_t;

  typedef struct packed {
    logic seg_valid;
    logic seg_last;
    logic len_small;
    logic dot_le0;
    logic dot_ge_len;
    logic out_free;
  } nps_stat_t;

endpackage

`default_nettype wire

[rtl/nps_if.sv]
// Channel interfaces: segment requests, result requests, configuration writes.
// Depends on nps_pkg for the register index width.
`default_nettype none

interface nps_seg_if #(
  parameter int CW = 20,
  parameter int NW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;
  logic signed [CW-1:0] start_z;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;
  logic signed [CW-1:0] end_z;
  logic [NW-1:0]        from_node;
  logic [NW-1:0]        to_node;
  logic                 segment_valid;
  logic                 last_segment;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  from_node, to_node, segment_valid, last_segment, input ready);
  modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  from_node, to_node, segment_valid, last_segment, output ready);
endinterface

interface nps_near_if #(
  parameter int CW = 20,
  parameter int NW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] near_x;
  logic signed [CW-1:0] near_y;
  logic signed [CW-1:0] near_z;
  logic [NW-1:0]        near_from;
  logic [NW-1:0]        near_to;
  logic                 found;

  modport source (output valid, near_x, near_y, near_z, near_from, near_to, found,
                  input ready);
  modport sink   (input valid, near_x, near_y, near_z, near_from, near_to, found,
                  output ready);
endinterface

interface nps_cfg_if #(
  parameter int CW = 20
);
  import nps_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [CW-1:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/nps_ctrl.sv]
// Sequencer for one segment request: lengths, dot, divide, point, distance.
// Depends on nps_pkg for the command and status structs.
`default_nettype none

module nps_ctrl
  import nps_pkg::*;
#(
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_fire,
  input  wire nps_stat_t stat,
  output logic           in_ready,
  output nps_cmd_t       cmd
);

  localparam int CNTW = $clog2(T_FRAC_BITS);

  typedef enum logic [3:0] {
    S_IDLE, S_LEN, S_DOT, S_CHECK, S_DIV, S_PT, S_DST, S_COMMIT, S_EMIT
  } state_t;

  state_t          state, state_next;
  logic [1:0]      axis, axis_next;
  logic [CNTW-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    axis_next  = axis;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.mul    = MK_NONE;
    cmd.axis   = axis;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = S_LEN;
          axis_next  = AXIS_X;
        end
      end
      S_LEN: begin
        if (!stat.seg_valid) begin
          state_next = stat.seg_last ? S_EMIT : S_IDLE;
        end else begin
          cmd.mul = MK_LEN;
          if (axis == AXIS_Z) begin
            state_next = S_DOT;
            axis_next  = AXIS_X;
          end else begin
            axis_next = axis + 2'd1;
          end
        end
      end
      S_DOT: begin
        cmd.mul = MK_DOT;
        if (axis == AXIS_Z) begin
          state_next = S_CHECK;
          axis_next  = AXIS_X;
        end else begin
          axis_next = axis + 2'd1;
        end
      end
      S_CHECK: begin
        priority if (stat.len_small || stat.dot_le0) begin
          cmd.pick_start = 1'b1;
          state_next     = S_DST;
        end else if (stat.dot_ge_len) begin
          cmd.pick_end = 1'b1;
          state_next   = S_DST;
        end else begin
          cmd.div_init = 1'b1;
          cnt_next     = '0;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNTW'(T_FRAC_BITS - 1)) begin
          state_next = S_PT;
        end else begin
          cnt_next = cnt + CNTW'(1);
        end
      end
      S_PT: begin
        cmd.mul = MK_PT;
        if (axis == AXIS_Z) begin
          state_next = S_DST;
          axis_next  = AXIS_X;
        end else begin
          axis_next = axis + 2'd1;
        end
      end
      S_DST: begin
        cmd.mul = MK_DST;
        if (axis == AXIS_Z) begin
          state_next = S_COMMIT;
          axis_next  = AXIS_X;
        end else begin
          axis_next = axis + 2'd1;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = stat.seg_last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      axis     <= AXIS_X;
      cnt      <= '0;
      in_ready <= 1'b0;
    end else begin
      state    <= state_next;
      axis     <= axis_next;
      cnt      <= cnt_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

`default_nettype wire

[rtl/nps_dp.sv]
// Datapath: query registers, shared multiplier with accumulators, restoring
// divider, running best and result register. Depends on nps_pkg.
`default_nettype none

module nps_dp
  import nps_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int NODE_BITS   = NODE_BITS_DEF,
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [COORD_BITS-1:0]        cfg_data,
  input  wire logic                         load,
  input  wire logic signed [COORD_BITS-1:0] in_sx,
  input  wire logic signed [COORD_BITS-1:0] in_sy,
  input  wire logic signed [COORD_BITS-1:0] in_sz,
  input  wire logic signed [COORD_BITS-1:0] in_ex,
  input  wire logic signed [COORD_BITS-1:0] in_ey,
  input  wire logic signed [COORD_BITS-1:0] in_ez,
  input  wire logic [NODE_BITS-1:0]         in_from,
  input  wire logic [NODE_BITS-1:0]         in_to,
  input  wire logic                         in_valid_seg,
  input  wire logic                         in_last,
  input  wire nps_cmd_t                     cmd,
  output nps_stat_t                         stat,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic signed [COORD_BITS-1:0]      out_x,
  output logic signed [COORD_BITS-1:0]      out_y,
  output logic signed [COORD_BITS-1:0]      out_z,
  output logic [NODE_BITS-1:0]              out_from,
  output logic [NODE_BITS-1:0]              out_to,
  output logic                              out_found
);

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;
  localparam int MW = (DW > T_FRAC_BITS + 2) ? DW : T_FRAC_BITS + 2;
  localparam int PW = 2 * MW;
  localparam int SW = 2 * DW + 2;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (T_FRAC_BITS - 1);

  logic signed [CW-1:0] qx, qy, qz;
  logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  logic signed [DW-1:0] abx, aby, abz, apx, apy, apz;
  logic [NODE_BITS-1:0] seg_from, seg_to;
  logic                 seg_valid, seg_last;
  logic signed [SW-1:0] len_acc, dot_acc, dst_acc;
  logic [SW-1:0]        rem;
  logic [T_FRAC_BITS-1:0] quot;
  logic [SW-1:0]        best_d;
  logic signed [CW-1:0] best_x, best_y, best_z;
  logic [NODE_BITS-1:0] best_from, best_to;
  logic                 any_found;

  logic signed [CW-1:0] a_sel, c_sel, q_sel;
  logic signed [DW-1:0] ab_sel, ap_sel, d_sel;
  logic signed [MW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod, rnd;
  logic signed [CW-1:0] pt;
  logic [SW:0]          rem2;

  always_comb begin
    unique case (cmd.axis)
      AXIS_Y: begin
        a_sel = ay; c_sel = cy; q_sel = qy; ab_sel = aby; ap_sel = apy;
      end
      AXIS_Z: begin
        a_sel = az; c_sel = cz; q_sel = qz; ab_sel = abz; ap_sel = apz;
      end
      default: begin
        a_sel = ax; c_sel = cx; q_sel = qx; ab_sel = abx; ap_sel = apx;
      end
    endcase
    d_sel = DW'(c_sel) - DW'(q_sel);
    unique case (cmd.mul)
      MK_LEN:  begin op_a = MW'(ab_sel); op_b = MW'(ab_sel); end
      MK_DOT:  begin op_a = MW'(ap_sel); op_b = MW'(ab_sel); end
      MK_PT:   begin op_a = MW'(ab_sel); op_b = MW'($signed({1'b0, quot})); end
      MK_DST:  begin op_a = MW'(d_sel);  op_b = MW'(d_sel); end
      default: begin op_a = '0;          op_b = '0; end
    endcase
    prod = op_a * op_b;
    // round half up, then back to coordinate scale
    rnd  = (prod + HALF) >>> T_FRAC_BITS;
    pt   = a_sel + CW'(rnd);
    rem2 = {rem, 1'b0};
  end

  assign stat.seg_valid  = seg_valid;
  assign stat.seg_last   = seg_last;
  assign stat.len_small  = (len_acc <= SW'(DEGEN_LIMIT));
  assign stat.dot_le0    = (dot_acc <= 0);
  assign stat.dot_ge_len = (dot_acc >= len_acc);
  assign stat.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      qx <= '0;
      qy <= '0;
      qz <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUERY_X: qx <= cfg_data;
        CFG_QUERY_Y: qy <= cfg_data;
        CFG_QUERY_Z: qz <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ax <= in_sx; ay <= in_sy; az <= in_sz;
      bx <= in_ex; by <= in_ey; bz <= in_ez;
      abx <= DW'(in_ex) - DW'(in_sx);
      aby <= DW'(in_ey) - DW'(in_sy);
      abz <= DW'(in_ez) - DW'(in_sz);
      apx <= DW'(qx) - DW'(in_sx);
      apy <= DW'(qy) - DW'(in_sy);
      apz <= DW'(qz) - DW'(in_sz);
      seg_from  <= in_from;
      seg_to    <= in_to;
      seg_valid <= in_valid_seg;
      seg_last  <= in_last;
      len_acc   <= '0;
      dot_acc   <= '0;
      dst_acc   <= '0;
    end else begin
      unique case (cmd.mul)
        MK_LEN: len_acc <= len_acc + SW'(prod);
        MK_DOT: dot_acc <= dot_acc + SW'(prod);
        MK_DST: dst_acc <= dst_acc + SW'(prod);
        MK_PT: begin
          unique case (cmd.axis)
            AXIS_Y:  cy <= pt;
            AXIS_Z:  cz <= pt;
            default: cx <= pt;
          endcase
        end
        default: ;
      endcase
      if (cmd.pick_start) begin
        cx <= ax; cy <= ay; cz <= az;
      end
      if (cmd.pick_end) begin
        cx <= bx; cy <= by; cz <= bz;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem  <= SW'(dot_acc);
      quot <= '0;
    end else if (cmd.div_step) begin
      if (rem2 >= {1'b0, len_acc}) begin
        rem  <= SW'(rem2 - {1'b0, len_acc});
        quot <= {quot[T_FRAC_BITS-2:0], 1'b1};
      end else begin
        rem  <= rem2[SW-1:0];
        quot <= {quot[T_FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      best_d    <= '1;
      best_x    <= '0;
      best_y    <= '0;
      best_z    <= '0;
      best_from <= '0;
      best_to   <= '0;
      any_found <= 1'b0;
    end else if (cmd.commit && ($unsigned(dst_acc) < best_d)) begin
      best_d    <= $unsigned(dst_acc);
      best_x    <= cx;
      best_y    <= cy;
      best_z    <= cz;
      best_from <= seg_from;
      best_to   <= seg_to;
      any_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (any_found) begin
        out_x <= best_x; out_y <= best_y; out_z <= best_z;
        out_from <= best_from; out_to <= best_to; out_found <= 1'b1;
      end else begin
        out_x <= qx; out_y <= qy; out_z <= qz;
        out_from <= '0; out_to <= '0; out_found <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/nearest_point_on_segment_set.sv]
// Channel  Dir  Handshake     Payload
// seg      in   valid/ready   start_x/y/z, end_x/y/z, from_node, to_node, segment_valid,
//                             last_segment
// near     out  valid/ready   near_x/y/z, near_from, near_to, found
// cfg      in   valid/ready   index (0 query_x, 1 query_y, 2 query_z), data
//
// One request at a time. A segment that projects inside runs the bit-per-cycle divider;
// clamped or degenerate segments skip the divider, and skipped ones go back to idle from
// the length step; a last request then also loads the result register once it is free.
// Synchronous reset clears query, running best and the control state.
// The result register holds while near.ready is low; a following request is still
// taken and only waits at its own result. cfg is always ready.
// Top level; depends on nps_pkg, nps_if, nps_ctrl and nps_dp.
`default_nettype none

module nearest_point_on_segment_set
  import nps_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int NODE_BITS   = NODE_BITS_DEF,
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  nps_seg_if.sink    seg,
  nps_near_if.source near,
  nps_cfg_if.sink    cfg
);

  nps_cmd_t  cmd;
  nps_stat_t stat;
  logic      in_ready;
  logic      in_fire;

  assign seg.ready = in_ready;
  assign in_fire   = seg.valid && in_ready;
  assign cfg.ready = 1'b1;

  nps_ctrl #(.T_FRAC_BITS(T_FRAC_BITS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  nps_dp #(
    .COORD_BITS  (COORD_BITS),
    .NODE_BITS   (NODE_BITS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .load         (in_fire),
    .in_sx        (seg.start_x),
    .in_sy        (seg.start_y),
    .in_sz        (seg.start_z),
    .in_ex        (seg.end_x),
    .in_ey        (seg.end_y),
    .in_ez        (seg.end_z),
    .in_from      (seg.from_node),
    .in_to        (seg.to_node),
    .in_valid_seg (seg.segment_valid),
    .in_last      (seg.last_segment),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (near.ready),
    .out_valid    (near.valid),
    .out_x        (near.near_x),
    .out_y        (near.near_y),
    .out_z        (near.near_z),
    .out_from     (near.near_from),
    .out_to       (near.near_to),
    .out_found    (near.found)
  );

endmodule

`default_nettype wire

[rtl/nps_check.sv]
// Port-level checks for nearest_point_on_segment_set, bound to the top level.
// Depends on nps_pkg for default widths and on the top level's channel interfaces.
`default_nettype none

module nps_check
  import nps_pkg::*;
#(
  parameter int PAY_W = 3 * COORD_BITS_DEF + 2 * NODE_BITS_DEF + 1
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             in_seg_valid,
  input wire logic             in_last,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic             out_found,
  input wire logic             out_nz_ids,
  input wire logic [PAY_W-1:0] out_payload
);

  // one request in flight: never ready straight after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // a skipped, non-last request frees the input on leaving the length state
  a_skip_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_seg_valid && !in_last |=> ##1 in_ready)
    else $error("skipped request held the input");

  // no segment found means cleared identifiers
  a_ids_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_found |-> !out_nz_ids)
    else $error("identifiers set without a found segment");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("stalled result changed");

endmodule

bind nearest_point_on_segment_set nps_check #(
  .PAY_W (3 * COORD_BITS + 2 * NODE_BITS + 1)
) u_nps_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (seg.valid),
  .in_ready     (seg.ready),
  .in_seg_valid (seg.segment_valid),
  .in_last      (seg.last_segment),
  .out_valid    (near.valid),
  .out_ready    (near.ready),
  .out_found    (near.found),
  .out_nz_ids   ((|near.near_from) || (|near.near_to)),
  .out_payload  ({near.near_x, near.near_y, near.near_z, near.near_from, near.near_to,
                  near.found})
);

`default_nettype wire
